FILE: hdl/fcts_pkg.sv
`timescale 1ns / 1ps
package fcts_pkg;

    localparam logic [1:0] MODE_FLOOR  = 2'd0;
    localparam logic [1:0] MODE_CEIL   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    localparam int CFG_IW = 3;
    localparam int CFG_NUM = 6;
    localparam logic [CFG_IW-1:0] CFG_PLAYER_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PLAYER_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_PLANE_Y  = 3'd5;

    localparam int TEX_DEPTH = 4096;
    localparam int TEX_AW = 12;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  screen_col;
        logic [7:0]  screen_row;
        logic [5:0]  tex_col;
        logic [5:0]  tex_row;
        logic [31:0] texel_rgba;
    } t_in;

    typedef struct packed {
        logic [8:0]  out_col;
        logic [7:0]  floor_row;
        logic [7:0]  ceil_row;
        logic [31:0] floor_rgba;
        logic [31:0] ceil_rgba;
        logic        row_ok;
    } t_out;

endpackage

FILE: hdl/floor_ceiling_texel_shader_top.sv
`timescale 1ns / 1ps
// Floor and ceiling texel shader. Mode 0/1 beats write one texel into the floor or ceiling
// store and produce no result; mode 2 beats render one lower-half pixel and its ceiling
// mirror. One beat is taken every clock while o_stall is low, loads and renders mixed freely.
// The pipeline depth is set by the division of the camera-plane term by SCREEN_WIDTH,
// done as a long division with four quotient bits per stage. Texel writes and reads
// happen in the same stage, so a load is seen by every later render. A two-entry output
// (result register plus skid) keeps the pipeline moving while one result is stalled, until
// the skid entry fills; o_stall comes from a register. Texels never written read back as
// arbitrary data.
module floor_ceiling_texel_shader_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int TEXTURE_SIZE  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  fcts_pkg::t_in               i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output fcts_pkg::t_out              o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fcts_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);

    localparam int HALF = SCREEN_HEIGHT / 2;
    localparam int DIW = $clog2(HALF);
    localparam int ROWW = ($clog2(SCREEN_HEIGHT + 1) > 8) ? $clog2(SCREEN_HEIGHT + 1) : 8;
    localparam int RDW = $clog2(SCREEN_HEIGHT * 32768 + 1);
    localparam int RDMW = RDW + 10;
    localparam int PHI = RDMW - 16;
    localparam int SW = RDMW + 34;
    localparam int DW = SW - 16;
    localparam int NDS = (DW + 3) / 4;
    localparam int DWP = NDS * 4;
    localparam int RW = $clog2(2 * SCREEN_WIDTH);
    localparam int TXW = $clog2(TEXTURE_SIZE);
    localparam int EW = RDW + 10;

    localparam int S_IN = 0;
    localparam int S_MUL = 1;
    localparam int S_PP = 2;
    localparam int S_SUM = 3;
    localparam int S_DIV = 4;
    localparam int S_FRAC = S_DIV + NDS;
    localparam int S_TC = S_FRAC + 1;
    localparam int S_ADR = S_TC + 1;
    localparam int S_MEM = S_ADR + 1;
    localparam int S_EST = S_MEM + 1;
    localparam int S_OUT = S_EST + 1;
    localparam int NS = S_OUT + 1;

    logic [RDW-1:0] w_rd_tab [HALF];
    logic [8:0]     w_rcp_tab [HALF];

    // row distance per row offset; offset zero never renders
    for (genvar g = 0; g < HALF; g++) begin : g_tab
        localparam int RD_G = (g == 0) ? 0 : (SCREEN_HEIGHT * 32768) / ((g == 0) ? 1 : g);
        // floor(2^25 / (2^17 + rowdist)), shade reciprocal
        localparam int RCP_G = (1 << 25) / (131072 + RD_G);
        assign w_rd_tab[g] = RDW'(RD_G);
        assign w_rcp_tab[g] = 9'(RCP_G);
    end

    typedef struct packed {
        logic                   load;
        logic                   ceil_sel;
        logic [11:0]            waddr;
        logic [31:0]            wdata;
        logic                   render;
        logic                   ok;
        logic [8:0]             col;
        logic [7:0]             row;
        logic [RDW-1:0]         rd;
        logic [8:0]             rcp;
        logic [9:0]             m;
        logic [RDMW-1:0]        rdm;
        logic [15:0]            ax;
        logic [15:0]            ay;
        logic signed [48:0]     plx;
        logic signed [48:0]     ply;
        logic signed [PHI+32:0] phx;
        logic signed [PHI+32:0] phy;
        logic signed [DWP-1:0]  dvx;
        logic signed [DWP-1:0]  dvy;
        logic [RW-1:0]          rx;
        logic [RW-1:0]          ry;
        logic [15:0]            qx;
        logic [15:0]            qy;
        logic [15:0]            fx;
        logic [15:0]            fy;
        logic [TXW-1:0]         tx;
        logic [TXW-1:0]         ty;
        logic [11:0]            raddr;
        logic [31:0]            fcol;
        logic [31:0]            ccol;
        logic [2:0][7:0]        estf;
        logic [2:0][7:0]        estc;
        logic [7:0]             crow;
        logic [31:0]            frgba;
        logic [31:0]            crgba;
    } t_pipe;

    logic [fcts_pkg::CFG_NUM-1:0][31:0] r_cfg;

    t_pipe r_p [NS];
    t_pipe n_p [NS];
    logic [NS-1:0] r_occ;
    logic w_en;
    logic w_in_occ;
    logic w_push;

    logic [31:0] r_mem_f [fcts_pkg::TEX_DEPTH];
    logic [31:0] r_mem_c [fcts_pkg::TEX_DEPTH];
    logic [31:0] r_ftex;
    logic [31:0] r_ctex;

    fcts_pkg::t_out r_o;
    fcts_pkg::t_out r_s;
    fcts_pkg::t_out w_res;
    logic r_o_v;
    logic r_s_v;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < fcts_pkg::CFG_NUM; i++) begin
                if (i_cfg_index == fcts_pkg::CFG_IW'(i)) begin
                    r_cfg[i] <= i_cfg_data;
                end
            end
        end
    end

    // the whole pipe moves together; the skid entry absorbs one result
    assign w_en = !r_s_v;
    assign o_stall = r_s_v;
    assign w_in_occ = i_valid && (i_data.mode == fcts_pkg::MODE_FLOOR ||
                                  i_data.mode == fcts_pkg::MODE_CEIL ||
                                  i_data.mode == fcts_pkg::MODE_RENDER);

    always_comb begin : c_in
        logic [ROWW-1:0] v_row;
        logic [ROWW-1:0] v_d;
        logic [DIW-1:0]  v_idx;
        logic [15:0]     v_la;
        v_row = ROWW'(i_data.screen_row);
        v_d = v_row - ROWW'(HALF);
        n_p[S_IN] = '0;
        n_p[S_IN].ok = (v_row > ROWW'(HALF)) && (v_row < ROWW'(SCREEN_HEIGHT));
        v_idx = n_p[S_IN].ok ? v_d[DIW-1:0] : '0;
        n_p[S_IN].rd = w_rd_tab[v_idx];
        n_p[S_IN].rcp = w_rcp_tab[v_idx];
        n_p[S_IN].load = (i_data.mode == fcts_pkg::MODE_FLOOR) ||
                         (i_data.mode == fcts_pkg::MODE_CEIL);
        n_p[S_IN].ceil_sel = (i_data.mode == fcts_pkg::MODE_CEIL);
        n_p[S_IN].render = (i_data.mode == fcts_pkg::MODE_RENDER);
        v_la = 16'(i_data.tex_row) * 16'(TEXTURE_SIZE) + 16'(i_data.tex_col);
        n_p[S_IN].waddr = v_la[11:0];
        n_p[S_IN].wdata = i_data.texel_rgba;
        n_p[S_IN].col = i_data.screen_col;
        n_p[S_IN].row = i_data.screen_row;
        n_p[S_IN].m = {i_data.screen_col, 1'b0};
    end

    always_comb begin : c_mul
        logic [31:0] v_ax;
        logic [31:0] v_ay;
        n_p[S_MUL] = r_p[S_IN];
        n_p[S_MUL].rdm = RDMW'(r_p[S_IN].rd) * RDMW'(r_p[S_IN].m);
        // only bits 31:16 of rowdist*(dir-plane) reach the fraction
        v_ax = 32'(r_p[S_IN].rd) * (r_cfg[fcts_pkg::CFG_DIR_X] - r_cfg[fcts_pkg::CFG_PLANE_X]);
        v_ay = 32'(r_p[S_IN].rd) * (r_cfg[fcts_pkg::CFG_DIR_Y] - r_cfg[fcts_pkg::CFG_PLANE_Y]);
        n_p[S_MUL].ax = v_ax[31:16];
        n_p[S_MUL].ay = v_ay[31:16];
    end

    always_comb begin : c_pp
        n_p[S_PP] = r_p[S_MUL];
        n_p[S_PP].plx = $signed({1'b0, r_p[S_MUL].rdm[15:0]}) *
                        $signed(r_cfg[fcts_pkg::CFG_PLANE_X]);
        n_p[S_PP].ply = $signed({1'b0, r_p[S_MUL].rdm[15:0]}) *
                        $signed(r_cfg[fcts_pkg::CFG_PLANE_Y]);
        n_p[S_PP].phx = $signed({1'b0, r_p[S_MUL].rdm[RDMW-1:16]}) *
                        $signed(r_cfg[fcts_pkg::CFG_PLANE_X]);
        n_p[S_PP].phy = $signed({1'b0, r_p[S_MUL].rdm[RDMW-1:16]}) *
                        $signed(r_cfg[fcts_pkg::CFG_PLANE_Y]);
    end

    always_comb begin : c_sum
        logic signed [SW-1:0] v_sx;
        logic signed [SW-1:0] v_sy;
        n_p[S_SUM] = r_p[S_PP];
        v_sx = (SW'(r_p[S_PP].phx) <<< 16) + SW'(r_p[S_PP].plx);
        v_sy = (SW'(r_p[S_PP].phy) <<< 16) + SW'(r_p[S_PP].ply);
        n_p[S_SUM].dvx = DWP'(v_sx >>> 16);
        n_p[S_SUM].dvy = DWP'(v_sy >>> 16);
        // negative dividend: leading ones stand for -1 = -1*W + (W-1)
        n_p[S_SUM].rx = v_sx[SW-1] ? RW'(SCREEN_WIDTH - 1) : '0;
        n_p[S_SUM].ry = v_sy[SW-1] ? RW'(SCREEN_WIDTH - 1) : '0;
        n_p[S_SUM].qx = '1;
        n_p[S_SUM].qy = '1;
    end

    // floor division by SCREEN_WIDTH, four bits per stage, msb first
    for (genvar j = 0; j < NDS; j++) begin : g_div
        always_comb begin
            logic [RW:0] v_rem;
            n_p[S_DIV+j] = r_p[S_DIV+j-1];
            for (int b = 0; b < 4; b++) begin
                v_rem = {n_p[S_DIV+j].rx, n_p[S_DIV+j].dvx[DWP-1-4*j-b]};
                if (v_rem >= (RW+1)'(SCREEN_WIDTH)) begin
                    v_rem = v_rem - (RW+1)'(SCREEN_WIDTH);
                    n_p[S_DIV+j].qx = {n_p[S_DIV+j].qx[14:0], 1'b1};
                end else begin
                    n_p[S_DIV+j].qx = {n_p[S_DIV+j].qx[14:0], 1'b0};
                end
                n_p[S_DIV+j].rx = v_rem[RW-1:0];
                v_rem = {n_p[S_DIV+j].ry, n_p[S_DIV+j].dvy[DWP-1-4*j-b]};
                if (v_rem >= (RW+1)'(SCREEN_WIDTH)) begin
                    v_rem = v_rem - (RW+1)'(SCREEN_WIDTH);
                    n_p[S_DIV+j].qy = {n_p[S_DIV+j].qy[14:0], 1'b1};
                end else begin
                    n_p[S_DIV+j].qy = {n_p[S_DIV+j].qy[14:0], 1'b0};
                end
                n_p[S_DIV+j].ry = v_rem[RW-1:0];
            end
        end
    end

    always_comb begin : c_frac
        n_p[S_FRAC] = r_p[S_FRAC-1];
        n_p[S_FRAC].fx = r_cfg[fcts_pkg::CFG_PLAYER_X][15:0] + r_p[S_FRAC-1].ax +
                         r_p[S_FRAC-1].qx;
        n_p[S_FRAC].fy = r_cfg[fcts_pkg::CFG_PLAYER_Y][15:0] + r_p[S_FRAC-1].ay +
                         r_p[S_FRAC-1].qy;
    end

    always_comb begin : c_tc
        logic [24:0] v_px;
        logic [24:0] v_py;
        n_p[S_TC] = r_p[S_FRAC];
        v_px = 25'(r_p[S_FRAC].fx) * 25'(TEXTURE_SIZE);
        v_py = 25'(r_p[S_FRAC].fy) * 25'(TEXTURE_SIZE);
        n_p[S_TC].tx = v_px[16 +: TXW];
        n_p[S_TC].ty = v_py[16 +: TXW];
    end

    always_comb begin : c_adr
        logic [19:0] v_t3;
        logic [16:0] v_a;
        n_p[S_ADR] = r_p[S_TC];
        // 2*tx/3 as a reciprocal multiply, exact below 2048
        v_t3 = 20'({r_p[S_TC].tx, 1'b0}) * 20'd683;
        v_a = 17'(r_p[S_TC].ty) * 17'(TEXTURE_SIZE) + 17'(v_t3[19:11]);
        n_p[S_ADR].raddr = v_a[11:0];
    end

    // texel writes and reads share this stage to keep beat order
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_occ[S_ADR] && r_p[S_ADR].load && !r_p[S_ADR].ceil_sel) begin
                r_mem_f[r_p[S_ADR].waddr] <= r_p[S_ADR].wdata;
            end
            r_ftex <= r_mem_f[r_p[S_ADR].raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_occ[S_ADR] && r_p[S_ADR].load && r_p[S_ADR].ceil_sel) begin
                r_mem_c[r_p[S_ADR].waddr] <= r_p[S_ADR].wdata;
            end
            r_ctex <= r_mem_c[r_p[S_ADR].raddr];
        end
    end

    always_comb begin : c_mem
        n_p[S_MEM] = r_p[S_ADR];
    end

    always_comb begin : c_est
        logic [16:0] v_pf;
        logic [16:0] v_pc;
        n_p[S_EST] = r_p[S_MEM];
        n_p[S_EST].fcol = r_ftex;
        n_p[S_EST].ccol = r_ctex;
        for (int c = 0; c < 3; c++) begin
            v_pf = 17'(r_ftex[8*(c+1) +: 8]) * 17'(r_p[S_MEM].rcp);
            v_pc = 17'(r_ctex[8*(c+1) +: 8]) * 17'(r_p[S_MEM].rcp);
            n_p[S_EST].estf[c] = v_pf[15:8];
            n_p[S_EST].estc[c] = v_pc[15:8];
        end
    end

    always_comb begin : c_out
        logic [EW-1:0]   v_den;
        logic [EW-1:0]   v_rem;
        logic [ROWW-1:0] v_crow;
        logic [7:0]      v_q;
        n_p[S_OUT] = r_p[S_EST];
        v_den = EW'(r_p[S_EST].rd) + EW'(131072);
        n_p[S_OUT].frgba = '0;
        n_p[S_OUT].crgba = '0;
        // estimate is low by at most one
        for (int c = 0; c < 3; c++) begin
            v_rem = (EW'(r_p[S_EST].fcol[8*(c+1) +: 8]) << 17) -
                    EW'(r_p[S_EST].estf[c]) * v_den;
            v_q = r_p[S_EST].estf[c] + 8'(v_rem >= v_den);
            n_p[S_OUT].frgba[8*(c+1) +: 8] = v_q;
            v_rem = (EW'(r_p[S_EST].ccol[8*(c+1) +: 8]) << 17) -
                    EW'(r_p[S_EST].estc[c]) * v_den;
            v_q = r_p[S_EST].estc[c] + 8'(v_rem >= v_den);
            n_p[S_OUT].crgba[8*(c+1) +: 8] = v_q;
        end
        n_p[S_OUT].frgba[7:0] = r_p[S_EST].fcol[7:0];
        n_p[S_OUT].crgba[7:0] = r_p[S_EST].ccol[7:0];
        v_crow = ROWW'(SCREEN_HEIGHT) - ROWW'(r_p[S_EST].row);
        n_p[S_OUT].crow = v_crow[7:0];
        if (!r_p[S_EST].ok) begin
            n_p[S_OUT].frgba = '0;
            n_p[S_OUT].crgba = '0;
            n_p[S_OUT].crow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (w_en) begin
            r_occ <= {r_occ[NS-2:0], w_in_occ};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NS; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    assign w_push = w_en && r_occ[S_OUT] && r_p[S_OUT].render;

    always_comb begin
        w_res.out_col = r_p[S_OUT].col;
        w_res.floor_row = r_p[S_OUT].row;
        w_res.ceil_row = r_p[S_OUT].crow;
        w_res.floor_rgba = r_p[S_OUT].frgba;
        w_res.ceil_rgba = r_p[S_OUT].crgba;
        w_res.row_ok = r_p[S_OUT].ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || !i_stall) begin
            if (r_s_v) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end else begin
                r_o_v <= w_push;
            end
        end else if (w_push) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || !i_stall) begin
            r_o <= r_s_v ? r_s : w_res;
        end else if (w_push) begin
            r_s <= w_res;
        end
    end

    assign o_valid = r_o_v;
    assign o_data = r_o;

endmodule

FILE: hdl/fcts_chk.sv
`timescale 1ns / 1ps
module fcts_chk #(
    parameter int SCREEN_HEIGHT = 240
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input fcts_pkg::t_out o_data
);

    // held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat dropped or changed under stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.row_ok |->
            o_data.floor_rgba == '0 && o_data.ceil_rgba == '0 && o_data.ceil_row == '0)
        else $error("out of range row with nonzero color");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.row_ok |->
            o_data.ceil_row == 8'(8'(SCREEN_HEIGHT) - o_data.floor_row) &&
            int'(o_data.floor_row) > SCREEN_HEIGHT / 2)
        else $error("ceiling row does not mirror floor row");

endmodule

bind floor_ceiling_texel_shader_top fcts_chk #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_fcts_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data(o_data)
);
